// File: hdl/imm_pkg.sv
// Shared constants, codes and types of the integer matrix multiply block.
package imm_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 6;
  localparam int CFG_W  = 7;
  localparam int FUNC_W = 2;
  localparam int CIDX_W = 2;

  localparam int DEF_MAX_DIM    = 64;
  localparam int DEF_TERM_GROUP = 4;
  localparam int DEF_DEPTH      = DEF_MAX_DIM * DEF_MAX_DIM;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_WR_A  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_COLS_B    = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET_VAL = 7'd64;

  typedef struct packed {
    logic clear;       // zero the accumulator for a new query
    logic term_valid;  // memory read data holds one term pair
  } mac_ctl_t;

endpackage

// File: hdl/imm_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module imm_ram #(
  parameter int WIDTH = imm_pkg::DATA_W,
  parameter int DEPTH = imm_pkg::DEF_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/imm_mac.sv
// Multiply-accumulate datapath: registered 32x32 product, wrapping 32-bit sum.
module imm_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  imm_pkg::mac_ctl_t                  ctl,
  input  logic signed [imm_pkg::DATA_W-1:0]  a_data,
  input  logic signed [imm_pkg::DATA_W-1:0]  b_data,
  output logic signed [imm_pkg::DATA_W-1:0]  acc,
  output logic                               pending
);

  logic signed [imm_pkg::DATA_W-1:0] mul_r, mul_nxt;
  logic signed [imm_pkg::DATA_W-1:0] acc_r, acc_nxt;
  logic                              mul_v_r;

  always_comb begin
    // low 32 bits only: the product wraps like the sum
    mul_nxt = imm_pkg::DATA_W'(a_data * b_data);
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (mul_v_r) begin
      acc_nxt = acc_r + mul_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else begin
      mul_v_r <= ctl.term_valid;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_nxt;
    acc_r <= acc_nxt;
  end

  assign acc     = acc_r;
  assign pending = mul_v_r;

endmodule

// File: hdl/integer_matrix_multiply_top.sv
// Top level of the integer matrix multiply block: control, stores and result port.
//
// Usage:
//   Input channel: raise start with in_func/in_row/in_col/in_value; the beat
//   is taken at a rising edge where start is high and busy is low.
//   func 0 writes one element of A, func 1 one element of B (out-of-range
//   writes are dropped); busy never rises for either.
//   func 2 queries C(row, col). The block walks the row of A and the column of
//   B through one multiplier and accumulator, one term per cycle, over
//   n = TERM_GROUP * floor(min(inner_len, MAX_DIM) / TERM_GROUP) terms.
//   The result beat is registered once the last term has left the store
//   read and multiplier registers; busy stays high until then. A query
//   outside rows_a or cols_b returns in_range 0 and value 0 and runs no terms.
//   Result channel: out_valid marks one beat for exactly one cycle; the
//   receiver cannot stall it, so take it when it shows.
//   Config channel: cfg_ready is always high; write rows_a, inner_len and
//   cols_b (index 0, 1, 2) only while the block is idle.
//   Reset (synchronous, active low) sets all three sizes to 64 and returns to
//   idle; the stores are not cleared, so read only entries already written.
module integer_matrix_multiply_top #(
  parameter int MAX_DIM    = imm_pkg::DEF_MAX_DIM,
  parameter int TERM_GROUP = imm_pkg::DEF_TERM_GROUP
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               start,
  output logic                               busy,
  input  logic [imm_pkg::FUNC_W-1:0]         in_func,
  input  logic [imm_pkg::IDX_W-1:0]          in_row,
  input  logic [imm_pkg::IDX_W-1:0]          in_col,
  input  logic signed [imm_pkg::DATA_W-1:0]  in_value,
  // result channel
  output logic                               out_valid,
  output logic [imm_pkg::IDX_W-1:0]          out_row,
  output logic [imm_pkg::IDX_W-1:0]          out_col,
  output logic signed [imm_pkg::DATA_W-1:0]  out_product_value,
  output logic                               out_in_range,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [imm_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]          cfg_data
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_DIM + 1);
  localparam int GW    = (TERM_GROUP > 1) ? $clog2(TERM_GROUP) : 1;
  localparam int CW    = KW + 5;  // holds sizes, MAX_DIM and k + TERM_GROUP

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [KW-1:0]              k_r, k_nxt;
  logic [GW-1:0]              g_r, g_nxt;
  logic [imm_pkg::IDX_W-1:0]  q_row_r, q_row_nxt;
  logic [imm_pkg::IDX_W-1:0]  q_col_r, q_col_nxt;
  logic                       q_ok_r, q_ok_nxt;
  logic                       rd_v_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [imm_pkg::IDX_W-1:0]  out_row_r;
  logic [imm_pkg::IDX_W-1:0]  out_col_r;
  logic signed [imm_pkg::DATA_W-1:0] out_value_r;
  logic                       out_in_range_r;
  logic [imm_pkg::CFG_W-1:0]  rows_a_r, inner_len_r, cols_b_r;

  logic                       accept, is_query, issue, finish;
  logic                       fits_a, fits_b, fits_q;
  logic [CW-1:0]              row_w, col_w, dim_w, m_eff;
  logic                       a_we, b_we;
  logic [AW-1:0]              w_addr, a_raddr, b_raddr;
  logic signed [imm_pkg::DATA_W-1:0] a_rdata, b_rdata, acc;
  logic                       mul_pending;
  imm_pkg::mac_ctl_t          mac_ctl;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign is_query  = (in_func == imm_pkg::FUNC_QUERY);

  // range checks against the configured sizes and the store bound
  always_comb begin
    row_w  = CW'(in_row);
    col_w  = CW'(in_col);
    dim_w  = CW'(MAX_DIM);
    fits_a = (row_w < CW'(rows_a_r)) && (col_w < CW'(inner_len_r))
             && (row_w < dim_w) && (col_w < dim_w);
    fits_b = (row_w < CW'(inner_len_r)) && (col_w < CW'(cols_b_r))
             && (row_w < dim_w) && (col_w < dim_w);
    fits_q = (row_w < CW'(rows_a_r)) && (col_w < CW'(cols_b_r))
             && (row_w < dim_w) && (col_w < dim_w);
    // saturate the inner length at the store size
    m_eff  = (CW'(inner_len_r) > dim_w) ? dim_w : CW'(inner_len_r);
  end

  // Writes land only while idle and reads only run while busy, so a read
  // and a write never touch the same entry in one cycle.
  assign a_we   = accept && (in_func == imm_pkg::FUNC_WR_A) && fits_a;
  assign b_we   = accept && (in_func == imm_pkg::FUNC_WR_B) && fits_b;
  assign w_addr = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);

  assign a_raddr = AW'(q_row_r) * AW'(MAX_DIM) + AW'(k_r);
  assign b_raddr = AW'(k_r) * AW'(MAX_DIM) + AW'(q_col_r);

  // Issue one term per cycle; open a new group of terms only if all of it fits.
  assign issue  = (state_r == ST_RUN)
                  && !((g_r == '0) && (CW'(k_r) + CW'(TERM_GROUP) > m_eff));
  // all issued terms have passed the memory and multiplier stages
  assign finish = (state_r == ST_DRAIN) && !rd_v_r && !mul_pending;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    q_row_nxt     = q_row_r;
    q_col_nxt     = q_col_r;
    q_ok_nxt      = q_ok_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_query) begin
          q_row_nxt = in_row;
          q_col_nxt = in_col;
          q_ok_nxt  = fits_q;
          k_nxt     = '0;
          g_nxt     = '0;
          state_nxt = fits_q ? ST_RUN : ST_DRAIN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          k_nxt = k_r + 1'b1;
          g_nxt = (g_r == GW'(TERM_GROUP - 1)) ? '0 : g_r + 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      g_r         <= '0;
      q_ok_r      <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      rows_a_r    <= imm_pkg::CFG_RESET_VAL;
      inner_len_r <= imm_pkg::CFG_RESET_VAL;
      cols_b_r    <= imm_pkg::CFG_RESET_VAL;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      g_r         <= g_nxt;
      q_ok_r      <= q_ok_nxt;
      rd_v_r      <= issue;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          imm_pkg::CFG_ROWS_A:    rows_a_r    <= cfg_data;
          imm_pkg::CFG_INNER_LEN: inner_len_r <= cfg_data;
          imm_pkg::CFG_COLS_B:    cols_b_r    <= cfg_data;
          default: begin
            // drop writes beyond the register list
          end
        endcase
      end
    end
  end

  // payload: hold the query position, load the result beat on finish
  always_ff @(posedge clk) begin
    q_row_r <= q_row_nxt;
    q_col_r <= q_col_nxt;
    if (finish) begin
      out_row_r      <= q_row_r;
      out_col_r      <= q_col_r;
      out_value_r    <= q_ok_r ? acc : '0;
      out_in_range_r <= q_ok_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_product_value = out_value_r;
  assign out_in_range      = out_in_range_r;

  imm_ram #(
    .WIDTH (imm_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (w_addr),
    .wdata (in_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  imm_ram #(
    .WIDTH (imm_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (w_addr),
    .wdata (in_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign mac_ctl.clear      = accept && is_query;
  assign mac_ctl.term_valid = rd_v_r;

  imm_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .a_data  (a_rdata),
    .b_data  (b_rdata),
    .acc     (acc),
    .pending (mul_pending)
  );

  // a result beat only follows the end of the drain
  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_DRAIN))
    else $error("result beat without a finished query");

  // no store write while a term is in flight
  a_no_write_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_v_r || mul_pending) |-> !(a_we || b_we))
    else $error("store write overlaps a running query");

  // the term counter never passes the saturated inner length
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (CW'(k_r) <= m_eff))
    else $error("term counter beyond inner length");

  // an out-of-range query returns a flagged beat without running the term loop
  a_oor_query: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_query && !fits_q) |-> ##2 (out_valid_r && !out_in_range_r))
    else $error("out-of-range query not answered in time");

endmodule

// File: tb/sv/integer_matrix_multiply_top_tb.sv
// Self-checking testbench for the integer matrix multiply block: stimulus, predictor, checks.
`timescale 1ns / 1ps

module integer_matrix_multiply_top_tb;
  import imm_pkg::*;

  localparam int MAX_DIM    = DEF_MAX_DIM;
  localparam int TERM_GROUP = DEF_TERM_GROUP;
  localparam int DEPTH      = MAX_DIM * MAX_DIM;

  // Func code the block defines no action for, and a register index past the list.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_UNUSED  = 2'd3;

  // Longest query: MAX_DIM terms plus the pipeline fill and the result beat.
  localparam int SETTLE_CYCLES = MAX_DIM + 8;
  // Cycles with no beat on any channel before the run is declared hung.
  localparam int QUIET_LIMIT   = 4000;
  localparam int PRINT_CAP     = 50;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } mm_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              in_range;
  } c_elem_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                      start     = 1'b0;
  logic                      busy;
  logic [FUNC_W-1:0]         in_func   = '0;
  logic [IDX_W-1:0]          in_row    = '0;
  logic [IDX_W-1:0]          in_col    = '0;
  logic signed [DATA_W-1:0]  in_value  = '0;
  logic                      out_valid;
  logic [IDX_W-1:0]          out_row;
  logic [IDX_W-1:0]          out_col;
  logic signed [DATA_W-1:0]  out_product_value;
  logic                      out_in_range;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CIDX_W-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data  = '0;

  integer_matrix_multiply_top #(
    .MAX_DIM   (MAX_DIM),
    .TERM_GROUP(TERM_GROUP)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_product_value(out_product_value),
    .out_in_range     (out_in_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shared helpers: which writes land and how many inner terms a query sums.
  // ---------------------------------------------------------------------------
  function automatic bit lands_in(input int unsigned r, c, rlim, clim);
    return r < rlim && c < clim && r < MAX_DIM && c < MAX_DIM;
  endfunction

  // Saturate to the store size, then keep whole groups of terms only.
  function automatic int unsigned used_terms(input int unsigned inner);
    int unsigned n;
    n = (inner > MAX_DIM) ? MAX_DIM : inner;
    return (n / TERM_GROUP) * TERM_GROUP;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor: mirror of both stores and the three size registers, updated on
  // every accepted beat. A query beat pushes the C element it must return.
  // ---------------------------------------------------------------------------
  bit [DATA_W-1:0] a_mirror [DEPTH];
  bit [DATA_W-1:0] b_mirror [DEPTH];
  int unsigned     mirror_rows  = CFG_RESET_VAL;
  int unsigned     mirror_inner = CFG_RESET_VAL;
  int unsigned     mirror_cols  = CFG_RESET_VAL;
  c_elem_t         expected_products [$];

  function automatic logic [DATA_W-1:0] dot_row_col(input int unsigned r, c);
    logic [DATA_W-1:0] sum;
    int unsigned       n;
    sum = '0;
    n   = used_terms(mirror_inner);
    // Both operands are 32 bits, so the product keeps only its low word.
    for (int unsigned k = 0; k < n; k++)
      sum += a_mirror[r * MAX_DIM + k] * b_mirror[k * MAX_DIM + c];
    return sum;
  endfunction

  function automatic void absorb_item(input logic [FUNC_W-1:0] f,
                                      input logic [IDX_W-1:0] r, c,
                                      input logic [DATA_W-1:0] v);
    c_elem_t elem;
    case (f)
      FUNC_WR_A: if (lands_in(r, c, mirror_rows, mirror_inner)) a_mirror[r * MAX_DIM + c] = v;
      FUNC_WR_B: if (lands_in(r, c, mirror_inner, mirror_cols)) b_mirror[r * MAX_DIM + c] = v;
      FUNC_QUERY: begin
        elem.row      = r;
        elem.col      = c;
        elem.in_range = lands_in(r, c, mirror_rows, mirror_cols);
        elem.value    = elem.in_range ? dot_row_col(r, c) : '0;
        expected_products.push_back(elem);
      end
      default: ;  // unused code: no store change, no result
    endcase
  endfunction

  function automatic void absorb_size(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    case (idx)
      CFG_ROWS_A:    mirror_rows  = d;
      CFG_INNER_LEN: mirror_inner = d;
      CFG_COLS_B:    mirror_cols  = d;
      default: ;  // index past the list is dropped
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning. The planner keeps its own view of the sizes and of which
  // store entries hold data, so that no query ever reads an entry never written:
  // before an in-range query it writes every missing A-row and B-column term.
  // ---------------------------------------------------------------------------
  mm_item_t    items_to_send [$];
  bit          a_filled [DEPTH];
  bit          b_filled [DEPTH];
  int unsigned plan_rows  = CFG_RESET_VAL;
  int unsigned plan_inner = CFG_RESET_VAL;
  int unsigned plan_cols  = CFG_RESET_VAL;
  int unsigned planned_count = 0;

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return DATA_W'(int'($urandom_range(15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic void plan_item(input logic [FUNC_W-1:0] f, input int unsigned r, c,
                                    input logic [DATA_W-1:0] v);
    mm_item_t it;
    it.func  = f;
    it.row   = IDX_W'(r);
    it.col   = IDX_W'(c);
    it.value = v;
    if (f == FUNC_WR_A && lands_in(it.row, it.col, plan_rows, plan_inner))
      a_filled[it.row * MAX_DIM + it.col] = 1'b1;
    if (f == FUNC_WR_B && lands_in(it.row, it.col, plan_inner, plan_cols))
      b_filled[it.row * MAX_DIM + it.col] = 1'b1;
    items_to_send.push_back(it);
    planned_count++;
  endfunction

  function automatic void plan_query(input int unsigned r, c, input logic [DATA_W-1:0] v);
    int unsigned n;
    if (lands_in(r, c, plan_rows, plan_cols)) begin
      n = used_terms(plan_inner);
      for (int unsigned k = 0; k < n; k++) begin
        if (!a_filled[r * MAX_DIM + k]) plan_item(FUNC_WR_A, r, k, rand_word());
        if (!b_filled[k * MAX_DIM + c]) plan_item(FUNC_WR_B, k, c, rand_word());
      end
    end
    plan_item(FUNC_QUERY, r, c, v);
  endfunction

  // Index limit for picks inside the configured sizes, narrowed by span so
  // that phases with long rows reuse a few rows and columns.
  function automatic int unsigned index_limit(input int unsigned size, span);
    int unsigned lim;
    lim = (size > MAX_DIM) ? MAX_DIM : size;
    return (lim > span) ? span : lim;
  endfunction

  function automatic int unsigned pick(input int unsigned lim);
    return (lim == 0) ? $urandom_range(MAX_DIM - 1) : $urandom_range(lim - 1);
  endfunction

  function automatic void plan_random(input int unsigned span);
    int unsigned roll, rlim, klim, clim, r, c;
    logic [FUNC_W-1:0] f;
    roll = $urandom_range(99);
    rlim = index_limit(plan_rows, span);
    klim = index_limit(plan_inner, MAX_DIM);
    clim = index_limit(plan_cols, span);
    if (roll < 26) begin
      plan_item(FUNC_WR_A, pick(rlim), pick(klim), rand_word());
    end else if (roll < 50) begin
      plan_item(FUNC_WR_B, pick(klim), pick(clim), rand_word());
    end else if (roll < 82) begin
      plan_query(pick(rlim), pick(clim), $urandom);
    end else if (roll < 91) begin
      // Noise over the whole index space; an in-range query here would drag in
      // a full row of fill writes, so turn it into a stray write instead.
      f = FUNC_W'($urandom_range(2));
      r = $urandom_range(MAX_DIM - 1);
      c = $urandom_range(MAX_DIM - 1);
      if (f == FUNC_QUERY && lands_in(r, c, plan_rows, plan_cols)) f = FUNC_WR_A;
      plan_item(f, r, c, $urandom);
    end else if (roll < 95) begin
      plan_item(FUNC_UNUSED, $urandom_range(MAX_DIM - 1), $urandom_range(MAX_DIM - 1), $urandom);
    end else if (roll[0]) begin
      // Just past the edge of A: one row too far or one column too far.
      if ($urandom_range(1)) plan_item(FUNC_WR_A, plan_rows, pick(klim), rand_word());
      else                   plan_item(FUNC_WR_A, pick(rlim), plan_inner, rand_word());
    end else begin
      if ($urandom_range(1)) plan_item(FUNC_WR_B, plan_inner, pick(clim), rand_word());
      else                   plan_item(FUNC_WR_B, pick(klim), plan_cols, rand_word());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present the next planned beat at the falling edge and hold it until
  // the block takes it. send_gap_pct sets how often a free slot is left empty.
  // ---------------------------------------------------------------------------
  int unsigned send_gap_pct = 0;
  bit          item_held    = 1'b0;
  mm_item_t    cur_item;

  always @(negedge clk) begin
    if (rst_n && !item_held && items_to_send.size() != 0 &&
        $urandom_range(99) >= send_gap_pct) begin
      cur_item  = items_to_send.pop_front();
      item_held = 1'b1;
      start    <= 1'b1;
      in_func  <= cur_item.func;
      in_row   <= cur_item.row;
      in_col   <= cur_item.col;
      in_value <= cur_item.value;
    end else if (!item_held) begin
      start <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge check the result beat against the oldest
  // expected C element, feed accepted input and size beats to the predictor,
  // and run the hang watchdog.
  // ---------------------------------------------------------------------------
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  bit          progressed;
  c_elem_t     want;

  task automatic flag_mismatch(input string what);
    if (mismatches < PRINT_CAP) $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      progressed = 1'b0;
      if (out_valid) begin
        progressed = 1'b1;
        if (expected_products.size() == 0) begin
          flag_mismatch($sformatf("result beat (%0d,%0d) with no query pending",
                                  out_row, out_col));
        end else begin
          want = expected_products.pop_front();
          if (out_row !== want.row)
            flag_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
          if (out_col !== want.col)
            flag_mismatch($sformatf("out_col %0d, want %0d", out_col, want.col));
          if (out_product_value !== want.value)
            flag_mismatch($sformatf("C(%0d,%0d) = %0d, want %0d", want.row, want.col,
                                    out_product_value, $signed(want.value)));
          if (out_in_range !== want.in_range)
            flag_mismatch($sformatf("C(%0d,%0d) in_range %b, want %b", want.row, want.col,
                                    out_in_range, want.in_range));
        end
      end
      if (start && !busy) begin
        progressed = 1'b1;
        absorb_item(in_func, in_row, in_col, in_value);
        item_held = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        progressed = 1'b1;
        absorb_size(cfg_index, cfg_data);
      end
      quiet_cycles = progressed ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing.
  // ---------------------------------------------------------------------------

  // Write all three sizes plus one write to the unused index; call at a
  // falling edge with the block idle. valid stays high across the burst.
  task automatic set_sizes(input int unsigned ra, il, cb);
    logic [CIDX_W-1:0] idx [4];
    logic [CFG_W-1:0]  dat [4];
    idx[0] = CFG_ROWS_A;    dat[0] = CFG_W'(ra);
    idx[1] = CFG_INNER_LEN; dat[1] = CFG_W'(il);
    idx[2] = CFG_COLS_B;    dat[2] = CFG_W'(cb);
    idx[3] = CFG_UNUSED;    dat[3] = CFG_W'($urandom);
    plan_rows  = dat[0];
    plan_inner = dat[1];
    plan_cols  = dat[2];
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drain: everything sent and every result back, then give a query that might
  // still be in flight time to finish. Returns at a falling edge.
  task automatic settle();
    while (items_to_send.size() != 0 || item_held || expected_products.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned ra, il, cb, span, budget);
    int unsigned stop_at;
    set_sizes(ra, il, cb);
    stop_at = planned_count + budget;
    while (planned_count < stop_at) plan_random(span);
    settle();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: tiny 2 x 4 x 2 problem with the corner values of a word.
    send_gap_pct = 15;
    set_sizes(2, 4, 2);
    plan_item(FUNC_WR_A, 0, 0, 32'h7FFF_FFFF);
    plan_item(FUNC_WR_A, 0, 1, 32'h8000_0000);
    plan_item(FUNC_WR_A, 0, 2, 32'hFFFF_FFFF);
    plan_item(FUNC_WR_A, 0, 3, 32'h0000_0001);
    plan_item(FUNC_WR_B, 0, 0, 32'h7FFF_FFFF);
    plan_item(FUNC_WR_B, 1, 0, 32'h8000_0000);
    plan_item(FUNC_WR_B, 2, 0, 32'hFFFF_FFFF);
    plan_item(FUNC_WR_B, 3, 0, 32'h0000_0000);
    plan_query(0, 0, 32'hFFFF_FFFF);
    // Writes just outside the sizes must leave the stores alone.
    plan_item(FUNC_WR_A, 0, 4, 32'h1234_5678);
    plan_item(FUNC_WR_A, 2, 0, 32'h1234_5678);
    plan_item(FUNC_WR_B, 4, 0, 32'h1234_5678);
    plan_item(FUNC_WR_B, 0, 2, 32'h1234_5678);
    plan_item(FUNC_UNUSED, MAX_DIM - 1, MAX_DIM - 1, 32'hFFFF_FFFF);
    plan_query(0, 0, 32'h0000_0000);
    // Queries outside the sizes come back flagged with a zero value; the last one is in range.
    plan_query(MAX_DIM - 1, MAX_DIM - 1, 32'h0000_0000);
    plan_query(2, 0, 32'h0000_0000);
    plan_query(0, 2, 32'h0000_0000);
    plan_query(1, 0, 32'h0000_0000);
    settle();

    // Random phases: sizes, index span, beat budget. Sender gaps at 15%, then
    // 54%, then none.
    run_phase(4, 8, 4, MAX_DIM, 120);
    run_phase(1, 4, 1, MAX_DIM, 60);
    run_phase(8, 3, 8, MAX_DIM, 60);      // fewer terms than one group: sum is 0
    send_gap_pct = 54;
    run_phase(3, 0, 5, MAX_DIM, 40);      // zero inner length
    run_phase(0, 12, 0, MAX_DIM, 40);     // empty A and C: all out of range
    run_phase(127, 127, 127, 1, 200);     // sizes past the store: saturate
    send_gap_pct = 0;
    run_phase(64, 64, 64, 2, 200);        // full size, back at reset values
    run_phase(64, 5, 64, MAX_DIM, 200);   // one group out of five inner terms
    run_phase(6, 16, 9, MAX_DIM, 120);

    if (expected_products.size() != 0)
      flag_mismatch($sformatf("%0d expected results never came", expected_products.size()));
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
